@@ hw/rtl/fpbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbp_pkg
// Shared types and constants of the fee priority bounded pool.
// ----------------------------------------------------------------------------
package fpbp_pkg;

    localparam int KEY_BITS   = 256;
    localparam int BYTES_W    = 20;
    localparam int TOTAL_W    = 27;
    localparam int OUT_CNT_W  = 7;
    localparam int OUT_BYTE_W = 26;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_DUMP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ADDED    = 3'd0,
        STS_DUP      = 3'd1,
        STS_REJECTED = 3'd2,
        STS_FOUND    = 3'd3,
        STS_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    // configuration register indexes
    localparam logic CFG_MAX_BYTES = 1'b0;
    localparam logic CFG_MAX_COUNT = 1'b1;

endpackage

@@ hw/rtl/fpbp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbp_in_if
// Command channel of the pool: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface fpbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [19:0] entry_bytes;
    logic [31:0] priority_rate;

    modport source (output valid, command, key_word0, key_word1, key_word2, key_word3,
                    entry_bytes, priority_rate, input ready);
    modport sink   (input valid, command, key_word0, key_word1, key_word2, key_word3,
                    entry_bytes, priority_rate, output ready);
endinterface

@@ hw/rtl/fpbp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbp_out_if
// Result channel of the pool: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface fpbp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  stored_count;
    logic [25:0] stored_bytes;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic [31:0] out_rate;
    logic        last_of_run;

    modport source (output valid, status, stored_count, stored_bytes, out_word0, out_word1,
                    out_word2, out_word3, out_rate, last_of_run, input ready);
    modport sink   (input valid, status, stored_count, stored_bytes, out_word0, out_word1,
                    out_word2, out_word3, out_rate, last_of_run, output ready);
endinterface

@@ hw/rtl/fpbp_rank_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbp_rank_cmp
// Ranks a scanned entry against the current best: lowest rate for eviction,
// highest rate for dump, ties broken by the smaller key in both cases.
// ----------------------------------------------------------------------------
module fpbp_rank_cmp
    import fpbp_pkg::*;
#(
    parameter int RATE_BITS = 32
) (
    input  logic [RATE_BITS-1:0] i_cand_rate,
    input  logic [KEY_BITS-1:0]  i_cand_key,
    input  logic [RATE_BITS-1:0] i_best_rate,
    input  logic [KEY_BITS-1:0]  i_best_key,
    input  logic                 i_max_mode,
    output logic                 o_better
);
    logic key_lt;
    logic rate_eq;
    logic rate_win;

    assign key_lt   = i_cand_key < i_best_key;
    assign rate_eq  = i_cand_rate == i_best_rate;
    // direction of the rate order depends on the search
    assign rate_win = i_max_mode ? (i_cand_rate > i_best_rate) : (i_cand_rate < i_best_rate);
    assign o_better = rate_win || (rate_eq && key_lt);
endmodule

@@ hw/rtl/fee_priority_bounded_pool.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fee_priority_bounded_pool
// Bounded pool of keyed entries with fee rate based eviction and sorted dump.
// ----------------------------------------------------------------------------
// Usage:
//  i_in carries one command transaction (add, remove, contains, dump); o_out
//  returns result transactions, last_of_run marking the final one of a command.
//  Entries live in a single-port-read, single-port-write memory of SLOT_COUNT
//  rows; every command walks that memory one row per cycle, and each scan is
//  followed by a decision step.
//  Remove and contains: one scan.
//  Add: one scan plus one rescan per evicted entry.
//  Dump of n entries: n scans, one result per scan.
//  The block takes a new command only when the previous one has finished;
//  results sit in an output register, and a stalled receiver holds the
//  sequencer in its decision cycle until the register frees up.
//  Reset clears the valid bits, the totals and restores the limits; memory
//  contents are not cleared, as invalid rows are never used. The user writes
//  config (i_cfg_we/i_cfg_idx/i_cfg_data) only while idle; it is not checked.
// ----------------------------------------------------------------------------
module fee_priority_bounded_pool
    import fpbp_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int RATE_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [TOTAL_W-1:0]   i_cfg_data,
    fpbp_in_if.sink              i_in,
    fpbp_out_if.source           o_out
);
    localparam int IW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int ENT_W = KEY_BITS + RATE_BITS + BYTES_W;

    // entry memory
    logic [ENT_W-1:0] mem [SLOT_COUNT];
    logic [ENT_W-1:0] r_rd_data;
    logic             rd_en;
    logic             mem_we;

    // control and status
    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [RATE_BITS-1:0]  r_rate, n_rate;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic [CW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_rd_pend, n_rd_pend;
    logic [IW-1:0]         r_data_idx, n_data_idx;
    logic                  r_first, n_first;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_hit_idx, n_hit_idx;
    logic [BYTES_W-1:0]    r_hit_bytes, n_hit_bytes;
    logic                  r_free_vld, n_free_vld;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic                  r_best_vld, n_best_vld;
    logic [IW-1:0]         r_best_idx, n_best_idx;
    logic [KEY_BITS-1:0]   r_best_key, n_best_key;
    logic [RATE_BITS-1:0]  r_best_rate, n_best_rate;
    logic [BYTES_W-1:0]    r_best_bytes, n_best_bytes;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [SLOT_COUNT-1:0] r_taken, n_taken;
    logic [CW-1:0]         r_entry_total, n_entry_total;
    logic [TOTAL_W-1:0]    r_byte_total, n_byte_total;
    logic [CW-1:0]         r_dump_cnt, n_dump_cnt;
    logic [TOTAL_W-1:0]    r_max_bytes;
    logic [6:0]            r_max_count;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [OUT_CNT_W-1:0]  r_out_count, n_out_count;
    logic [OUT_BYTE_W-1:0] r_out_bytes, n_out_bytes;
    logic [KEY_BITS-1:0]   r_out_key, n_out_key;
    logic [31:0]           r_out_rate, n_out_rate;
    logic                  r_out_last, n_out_last;

    // scan data fields
    logic [KEY_BITS-1:0]   d_key;
    logic [RATE_BITS-1:0]  d_rate;
    logic [BYTES_W-1:0]    d_bytes;
    logic                  d_valid;
    logic                  d_cand;
    logic                  d_better;
    logic                  emit;
    logic                  out_free;
    logic [CW-1:0]         lim;
    logic                  over;

    assign d_key   = r_rd_data[ENT_W-1 -: KEY_BITS];
    assign d_rate  = r_rd_data[BYTES_W +: RATE_BITS];
    assign d_bytes = r_rd_data[BYTES_W-1:0];
    assign d_valid = r_valid[r_data_idx];
    assign d_cand  = d_valid && !(r_cmd == CMD_DUMP && r_taken[r_data_idx]);

    assign rd_en    = (r_state == S_SCAN) && (r_rd_idx < CW'(SLOT_COUNT));
    assign out_free = !r_out_valid || o_out.ready;

    // effective entry limit and the overflow test for add
    assign lim  = (32'(r_max_count) > SLOT_COUNT) ? CW'(SLOT_COUNT) : CW'(r_max_count);
    assign over = ((28'(r_byte_total) + 28'(r_bytes)) > 28'(r_max_bytes)) ||
                  (r_entry_total >= lim);

    fpbp_rank_cmp #(
        .RATE_BITS (RATE_BITS)
    ) u_rank (
        .i_cand_rate (d_rate),
        .i_cand_key  (d_key),
        .i_best_rate (r_best_rate),
        .i_best_key  (r_best_key),
        .i_max_mode  (r_cmd == CMD_DUMP),
        .o_better    (d_better)
    );

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_free_idx] <= {r_key, r_rate, r_bytes};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[IW-1:0]];
        end
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_rate       = r_rate;
        n_bytes      = r_bytes;
        n_rd_idx     = r_rd_idx;
        n_rd_pend    = r_rd_pend;
        n_data_idx   = r_data_idx;
        n_first      = r_first;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_bytes  = r_hit_bytes;
        n_free_vld   = r_free_vld;
        n_free_idx   = r_free_idx;
        n_best_vld   = r_best_vld;
        n_best_idx   = r_best_idx;
        n_best_key   = r_best_key;
        n_best_rate  = r_best_rate;
        n_best_bytes = r_best_bytes;
        n_valid      = r_valid;
        n_taken      = r_taken;
        n_entry_total = r_entry_total;
        n_byte_total = r_byte_total;
        n_dump_cnt   = r_dump_cnt;
        n_out_valid  = o_out.ready ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_bytes  = r_out_bytes;
        n_out_key    = r_out_key;
        n_out_rate   = r_out_rate;
        n_out_last   = r_out_last;
        emit         = 1'b0;
        mem_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                // take a command transaction and start the first scan
                if (i_in.valid) begin
                    n_cmd      = t_cmd'(i_in.command);
                    n_key      = {i_in.key_word0, i_in.key_word1,
                                  i_in.key_word2, i_in.key_word3};
                    n_rate     = RATE_BITS'(i_in.priority_rate);
                    n_bytes    = i_in.entry_bytes;
                    n_rd_idx   = '0;
                    n_rd_pend  = 1'b0;
                    n_first    = 1'b1;
                    n_hit      = 1'b0;
                    n_free_vld = 1'b0;
                    n_best_vld = 1'b0;
                    n_taken    = '0;
                    n_dump_cnt = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one row read per cycle, evaluate the row read last cycle
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                n_rd_pend  = rd_en;
                n_data_idx = r_rd_idx[IW-1:0];
                if (r_rd_pend) begin
                    if (r_first && d_valid && d_key == r_key) begin
                        n_hit       = 1'b1;
                        n_hit_idx   = r_data_idx;
                        n_hit_bytes = d_bytes;
                    end
                    if (r_first && !d_valid && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_data_idx;
                    end
                    if (d_cand && (!r_best_vld || d_better)) begin
                        n_best_vld   = 1'b1;
                        n_best_idx   = r_data_idx;
                        n_best_key   = d_key;
                        n_best_rate  = d_rate;
                        n_best_bytes = d_bytes;
                    end
                end
                if (!rd_en && !r_rd_pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_out_key  = '0;
                    n_out_rate = '0;
                    n_out_last = 1'b1;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (r_hit) begin
                                emit         = 1'b1;
                                n_out_status = STS_DUP;
                            end else if (over && r_entry_total != '0) begin
                                if (!(r_rate > r_best_rate)) begin
                                    emit         = 1'b1;
                                    n_out_status = STS_REJECTED;
                                end else begin
                                    // evict the lowest entry and rescan for the next one
                                    n_valid[r_best_idx] = 1'b0;
                                    n_entry_total = r_entry_total - CW'(1);
                                    n_byte_total  = r_byte_total - TOTAL_W'(r_best_bytes);
                                    if (!r_free_vld || r_best_idx < r_free_idx) begin
                                        n_free_idx = r_best_idx;
                                    end
                                    n_free_vld = 1'b1;
                                    n_first    = 1'b0;
                                    n_best_vld = 1'b0;
                                    n_rd_idx   = '0;
                                    n_rd_pend  = 1'b0;
                                    n_state    = S_SCAN;
                                end
                            end else if (!r_free_vld) begin
                                emit         = 1'b1;
                                n_out_status = STS_REJECTED;
                            end else begin
                                mem_we              = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_entry_total = r_entry_total + CW'(1);
                                n_byte_total  = r_byte_total + TOTAL_W'(r_bytes);
                                emit          = 1'b1;
                                n_out_status  = STS_ADDED;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_entry_total = r_entry_total - CW'(1);
                                n_byte_total  = r_byte_total - TOTAL_W'(r_hit_bytes);
                            end
                            emit         = 1'b1;
                            n_out_status = r_hit ? STS_FOUND : STS_NOTFOUND;
                        end
                        CMD_CONTAINS: begin
                            emit         = 1'b1;
                            n_out_status = r_hit ? STS_FOUND : STS_NOTFOUND;
                        end
                        CMD_DUMP: begin
                            emit = 1'b1;
                            if (r_entry_total == '0) begin
                                n_out_status = STS_NOTFOUND;
                            end else begin
                                // one entry per scan in descending rate order
                                n_out_status         = STS_FOUND;
                                n_out_key            = r_best_key;
                                n_out_rate           = 32'(r_best_rate);
                                n_out_last           = (r_dump_cnt == r_entry_total - CW'(1));
                                n_taken[r_best_idx]  = 1'b1;
                                n_dump_cnt           = r_dump_cnt + CW'(1);
                                if (!n_out_last) begin
                                    n_best_vld = 1'b0;
                                    n_rd_idx   = '0;
                                    n_rd_pend  = 1'b0;
                                    n_state    = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            emit         = 1'b1;
                            n_out_status = STS_NOTFOUND;
                        end
                    endcase
                    if (emit && n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result totals, saturated to the field widths
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_count = (32'(n_entry_total) > 127) ? '1 : OUT_CNT_W'(n_entry_total);
            n_out_bytes = (n_byte_total > TOTAL_W'(67108863)) ? '1 :
                          n_byte_total[OUT_BYTE_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rd_pend     <= 1'b0;
            r_valid       <= '0;
            r_entry_total <= '0;
            r_byte_total  <= '0;
            r_out_valid   <= 1'b0;
            r_max_bytes   <= TOTAL_W'(67108864);
            r_max_count   <= 7'd64;
        end else begin
            r_state       <= n_state;
            r_rd_pend     <= n_rd_pend;
            r_valid       <= n_valid;
            r_entry_total <= n_entry_total;
            r_byte_total  <= n_byte_total;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                    CFG_MAX_COUNT: r_max_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_rate       <= n_rate;
        r_bytes      <= n_bytes;
        r_rd_idx     <= n_rd_idx;
        r_data_idx   <= n_data_idx;
        r_first      <= n_first;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_bytes  <= n_hit_bytes;
        r_free_vld   <= n_free_vld;
        r_free_idx   <= n_free_idx;
        r_best_vld   <= n_best_vld;
        r_best_idx   <= n_best_idx;
        r_best_key   <= n_best_key;
        r_best_rate  <= n_best_rate;
        r_best_bytes <= n_best_bytes;
        r_taken      <= n_taken;
        r_dump_cnt   <= n_dump_cnt;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_bytes  <= n_out_bytes;
        r_out_key    <= n_out_key;
        r_out_rate   <= n_out_rate;
        r_out_last   <= n_out_last;
    end

    // channel drive
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.stored_count = r_out_count;
    assign o_out.stored_bytes = r_out_bytes;
    assign o_out.out_word0    = r_out_key[255:192];
    assign o_out.out_word1    = r_out_key[191:128];
    assign o_out.out_word2    = r_out_key[127:64];
    assign o_out.out_word3    = r_out_key[63:0];
    assign o_out.out_rate     = r_out_rate;
    assign o_out.last_of_run  = r_out_last;

    // running count agrees with the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_entry_total))
        else $error("entry count differs from valid slot count");

    // an add only writes into a free slot
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_valid[r_free_idx])
        else $error("add overwrites a valid slot");

    // a non-empty dump always has a selected entry
    a_dump_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_cmd == CMD_DUMP && r_entry_total != '0) |-> r_best_vld)
        else $error("dump step without a selected entry");

    // no new transaction while a command is in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_in.ready)
        else $error("command accepted during a scan");
endmodule
